// ----- src/tpml_pkg.sv -----
// Shared types and constants for the text pattern match locator.
// Used by the cell chain, the result buffer and the top level.
package tpml_pkg;

    // Fixed widths of the result fields and of the pattern register
    localparam int OUT_W             = 24;
    localparam int PATTERN_REG_BYTES = 8;
    localparam int LEN_W             = 4;

    localparam logic [7:0]       NEWLINE_CODE = 8'h0A;
    localparam logic [OUT_W-1:0] COUNT_MAX    = {OUT_W{1'b1}};

    // Register select, taken from paddr[3]
    localparam logic REG_PATTERN_BYTES  = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } text_t;

    typedef struct packed {
        logic             match_found;
        logic [OUT_W-1:0] match_start;
        logic [OUT_W-1:0] match_line;
        logic [OUT_W-1:0] match_column;
        logic [OUT_W-1:0] match_total;
        logic             end_of_text;
    } result_t;

    // Per-cycle control shared by every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// ----- src/text_pattern_match_locator_unit.sv -----
// Text pattern match locator: top level with APB registers, cell chain and counters.
// Depends on tpml_pkg, tpml_cell and tpml_out_buf.
//
// Usage: text bytes arrive on the text channel (text_valid/text_stall/text_data),
// one request per byte, last_byte set on the final byte of a buffer. Every
// accepted byte yields exactly one result request on the result channel
// (result_valid/result_stall/result_data): match flag, start index, line and
// column of an occurrence ending on this byte, and the saturating match total.
// Throughput is one byte per cycle while text_stall is low; the compare runs on the
// byte entering the cell chain, and each result is registered in the output buffer.
// The result channel has an output register plus a skid stage: while the
// receiver stalls, one more byte is taken, then text_stall rises until the
// receiver takes the held result. After the final byte of a buffer, the window
// and counters return to zero; the registers keep their values.
// Registers: pattern bytes at 0x0, pattern length at 0x8 (64-bit APB data).
// Reset clears window, counters and result channel; pattern is 0, length 1.
module text_pattern_match_locator_unit #(
    parameter int MAX_PATTERN   = 8,
    parameter int POSITION_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_valid,
    output logic              text_stall,
    input  tpml_pkg::text_t   text_data,
    output logic              result_valid,
    input  logic              result_stall,
    output tpml_pkg::result_t result_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import tpml_pkg::*;

    localparam int EFF_MAX = (MAX_PATTERN < PATTERN_REG_BYTES) ? MAX_PATTERN
                                                               : PATTERN_REG_BYTES;
    localparam logic [LEN_W-1:0] EFF_MAX_L = LEN_W'(EFF_MAX);

    // Configuration registers
    logic [63:0]      pattern_reg;
    logic [LEN_W-1:0] length_reg;
    logic             cfg_write;

    // Stream counters
    logic [POSITION_BITS-1:0] byte_index_reg, byte_index_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [OUT_W-1:0]         found_reg, found_next;

    // Cell chain signals
    logic                     d_valid [MAX_PATTERN];
    logic [7:0]               d_byte  [MAX_PATTERN];
    logic [POSITION_BITS-1:0] d_line  [MAX_PATTERN];
    logic [POSITION_BITS-1:0] d_col   [MAX_PATTERN];
    logic                     q_valid [MAX_PATTERN];
    logic [7:0]               q_byte  [MAX_PATTERN];
    logic [POSITION_BITS-1:0] q_line  [MAX_PATTERN];
    logic [POSITION_BITS-1:0] q_col   [MAX_PATTERN];
    logic [7:0]               want    [MAX_PATTERN];
    logic                     eq      [MAX_PATTERN];
    cell_ctrl_t               ctrl;

    logic                     accept;
    logic [LEN_W-1:0]         eff_len;
    logic                     all_eq;
    logic                     sel_valid;
    logic [POSITION_BITS-1:0] sel_line;
    logic [POSITION_BITS-1:0] sel_col;
    logic [POSITION_BITS-1:0] occ_start;
    logic                     hit;
    result_t                  result;

    // APB write and read decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[3])
                REG_PATTERN_BYTES:  pattern_reg <= pwdata;
                REG_PATTERN_LENGTH: length_reg  <= pwdata[LEN_W-1:0];
                default:            pattern_reg <= pattern_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            REG_PATTERN_BYTES:  prdata = pattern_reg;
            REG_PATTERN_LENGTH: prdata = {{(64-LEN_W){1'b0}}, length_reg};
            default:            prdata = '0;
        endcase
    end

    assign accept     = text_valid && !text_stall;
    assign ctrl.shift = accept;
    assign ctrl.clear = accept && text_data.last_byte;

    // Cap the length at the window depth and the pattern register size
    assign eff_len = (length_reg > EFF_MAX_L) ? EFF_MAX_L : length_reg;

    // Route the pattern byte each cell compares against
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            want[j] = '0;
            for (int k = 0; k < PATTERN_REG_BYTES; k++)
            begin
                if (j < EFF_MAX && (j + k + 1) == int'(eff_len))
                    want[j] = pattern_reg[8*k +: 8];
            end
        end
    end

    // Feed the chain: newest byte enters cell 0, each cell takes its left neighbor
    assign d_valid[0] = 1'b1;
    assign d_byte[0]  = text_data.text_byte;
    assign d_line[0]  = line_reg;
    assign d_col[0]   = col_reg;

    for (genvar g = 0; g < MAX_PATTERN; g++)
    begin : g_cell
        if (g > 0)
        begin : g_link
            assign d_valid[g] = q_valid[g-1];
            assign d_byte[g]  = q_byte[g-1];
            assign d_line[g]  = q_line[g-1];
            assign d_col[g]   = q_col[g-1];
        end

        tpml_cell #(
            .POS_W (POSITION_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .d_valid (d_valid[g]),
            .d_byte  (d_byte[g]),
            .d_line  (d_line[g]),
            .d_col   (d_col[g]),
            .want    (want[g]),
            .eq      (eq[g]),
            .q_valid (q_valid[g]),
            .q_byte  (q_byte[g]),
            .q_line  (q_line[g]),
            .q_col   (q_col[g])
        );
    end

    // Combine cell compares and pick the start entry of the occurrence
    always_comb
    begin
        all_eq    = 1'b1;
        sel_valid = 1'b0;
        sel_line  = '0;
        sel_col   = '0;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (j < int'(eff_len) && !eq[j])
                all_eq = 1'b0;
            if ((j + 1) == int'(eff_len))
            begin
                sel_valid = d_valid[j];
                sel_line  = d_line[j];
                sel_col   = d_col[j];
            end
        end
    end

    assign hit = (eff_len != '0) && sel_valid && all_eq &&
                 !(text_data.last_byte && eff_len == LEN_W'(1));

    assign occ_start = byte_index_reg - POSITION_BITS'(eff_len - LEN_W'(1));

    // Advance position and match counters; clear them on the final byte
    always_comb
    begin
        byte_index_next = byte_index_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        found_next      = found_reg;
        if (accept)
        begin
            if (text_data.last_byte)
            begin
                byte_index_next = '0;
                line_next       = '0;
                col_next        = '0;
                found_next      = '0;
            end
            else
            begin
                byte_index_next = byte_index_reg + POSITION_BITS'(1);
                if (text_data.text_byte == NEWLINE_CODE)
                begin
                    line_next = line_reg + POSITION_BITS'(1);
                    col_next  = '0;
                end
                else
                begin
                    col_next = col_reg + POSITION_BITS'(1);
                end
                if (hit && found_reg != COUNT_MAX)
                    found_next = found_reg + OUT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            line_reg       <= '0;
            col_reg        <= '0;
            found_reg      <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            found_reg      <= found_next;
        end
    end

    // Build the result request for this byte
    always_comb
    begin
        result.match_found  = hit;
        result.match_start  = hit ? OUT_W'(occ_start) : '0;
        result.match_line   = hit ? OUT_W'(sel_line) : '0;
        result.match_column = hit ? OUT_W'(sel_col) : '0;
        result.match_total  = (hit && found_reg != COUNT_MAX) ? found_reg + OUT_W'(1)
                                                              : found_reg;
        result.end_of_text  = text_data.last_byte;
    end

    tpml_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (text_stall),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (result_data)
    );

endmodule

// ----- src/tpml_cell.sv -----
// One window cell: holds a byte with its line and column and a valid flag.
// Depends on tpml_pkg for the control struct.
module tpml_cell #(
    parameter int POS_W = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpml_pkg::cell_ctrl_t ctrl,
    input  logic                 d_valid,
    input  logic [7:0]           d_byte,
    input  logic [POS_W-1:0]     d_line,
    input  logic [POS_W-1:0]     d_col,
    input  logic [7:0]           want,
    output logic                 eq,
    output logic                 q_valid,
    output logic [7:0]           q_byte,
    output logic [POS_W-1:0]     q_line,
    output logic [POS_W-1:0]     q_col
);
    import tpml_pkg::*;

    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic [POS_W-1:0] line_reg;
    logic [POS_W-1:0] col_reg;

    // Compare the byte entering this cell against its pattern byte
    assign eq = (d_byte == want);

    // Take the neighbor's entry on shift, drop everything at end of text
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            byte_reg  <= '0;
            line_reg  <= '0;
            col_reg   <= '0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
            byte_reg  <= '0;
            line_reg  <= '0;
            col_reg   <= '0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= d_valid;
            byte_reg  <= d_byte;
            line_reg  <= d_line;
            col_reg   <= d_col;
        end
    end

    assign q_valid = valid_reg;
    assign q_byte  = byte_reg;
    assign q_line  = line_reg;
    assign q_col   = col_reg;

endmodule

// ----- src/tpml_out_buf.sv -----
// Result output register with a skid stage behind it.
// Depends on tpml_pkg for the result struct.
module tpml_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tpml_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output tpml_pkg::result_t out_data
);
    import tpml_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && !out_stall;

    // Refill the output from the skid first, else from a new request; a push into a full output waits in the skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- bench/text_pattern_match_locator_unit_test.sv -----
// Testbench for text_pattern_match_locator_unit: streams text requests, predicts each result
// request and compares it field by field. Depends on tpml_pkg and the RTL under src/.
module text_pattern_match_locator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tpml_pkg::*;

    localparam int MAX_PAT       = 8;
    localparam int WAIT_MAX      = 14;
    localparam int RANDOM_ITEMS  = 450;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_LIMIT    = 3000;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_B = 8'h62;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        text_valid   = 1'b0;
    logic        text_stall;
    text_t       text_data    = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result_data;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [63:0] pwdata       = '0;
    logic [63:0] prdata;
    logic        pready;

    text_pattern_match_locator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_data    (text_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Mirror of the registers and of the search window
    logic [63:0]      cfg_pattern;
    logic [LEN_W-1:0] cfg_length;
    logic [7:0]       win_byte [MAX_PAT];
    logic [OUT_W-1:0] win_line [MAX_PAT];
    logic [OUT_W-1:0] win_col  [MAX_PAT];
    logic [OUT_W-1:0] pos_index;
    logic [OUT_W-1:0] pos_line;
    logic [OUT_W-1:0] pos_col;
    logic [OUT_W-1:0] hit_count;
    int               fill;

    text_t   pending_text[$];
    result_t predicted_results[$];

    int failures      = 0;
    int bytes_queued  = 0;
    int bytes_taken   = 0;
    int send_idle_pct = 30;
    int recv_idle_pct = 30;
    int text_gap      = 0;
    int stall_left    = 0;
    int idle_cycles   = 0;
    logic text_taken   = 1'b0;
    logic result_taken = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_stream();
        for (int i = 0; i < MAX_PAT; i++)
        begin
            win_byte[i] = '0;
            win_line[i] = '0;
            win_col[i]  = '0;
        end
        pos_index = '0;
        pos_line  = '0;
        pos_col   = '0;
        hit_count = '0;
        fill      = 0;
    endfunction

    // Shift one byte into the window and work out the result request it causes
    function automatic result_t locate_match(input text_t item);
        result_t r;
        int      span;
        bit      hit;
        span = (cfg_length > MAX_PAT) ? MAX_PAT : int'(cfg_length);
        for (int i = MAX_PAT - 1; i > 0; i--)
        begin
            win_byte[i] = win_byte[i-1];
            win_line[i] = win_line[i-1];
            win_col[i]  = win_col[i-1];
        end
        win_byte[0] = item.text_byte;
        win_line[0] = pos_line;
        win_col[0]  = pos_col;
        if (fill < MAX_PAT)
            fill++;
        r = '0;
        // a single-byte pattern may not start on the final byte
        if (span >= 1 && fill >= span && !(item.last_byte && span == 1))
        begin
            hit = 1'b1;
            for (int k = 0; k < span; k++)
                if (win_byte[span-1-k] != cfg_pattern[8*k +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                r.match_found  = 1'b1;
                r.match_start  = pos_index - OUT_W'(span - 1);
                r.match_line   = win_line[span-1];
                r.match_column = win_col[span-1];
                if (hit_count != COUNT_MAX)
                    hit_count++;
            end
        end
        r.match_total = hit_count;
        r.end_of_text = item.last_byte;
        // advance the position of the next byte
        if (item.text_byte == NEWLINE_CODE)
        begin
            pos_line++;
            pos_col = '0;
        end
        else
            pos_col++;
        pos_index++;
        if (item.last_byte)
            clear_stream();
        return r;
    endfunction

    function automatic int draw_wait(input int pct);
        return ($urandom_range(0, 99) < pct) ? int'($urandom_range(0, WAIT_MAX)) : 0;
    endfunction

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want)
        begin
            failures++;
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // Write a register through the APB port, then read it back
    task automatic set_reg(input logic sel, input logic [63:0] value);
        logic [63:0] want;
        want = (sel == REG_PATTERN_BYTES) ? value : {60'b0, value[3:0]};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (sel == REG_PATTERN_BYTES)
            cfg_pattern = value;
        else
            cfg_length = value[LEN_W-1:0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            failures++;
            $display("%0t ns: register %0d read expected %h actual %h", $time, sel, want, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_text(input logic [7:0] ch, input logic last);
        text_t item;
        item.text_byte = ch;
        item.last_byte = last;
        pending_text.push_back(item);
        bytes_queued++;
    endtask

    task automatic queue_string(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            queue_text(s[i], close && i == s.len() - 1);
    endtask

    // Pattern bytes, planted whole copies and newlines, mixed with noise_pct percent noise
    task automatic queue_buffer(input int count, input bit close, input int noise_pct);
        int          span;
        int          made;
        int          pick;
        logic [7:0]  ch;
        span = (cfg_length > MAX_PAT) ? MAX_PAT : int'(cfg_length);
        if (span == 0)
            span = 4;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                for (int k = 0; k < span && made < count; k++)
                begin
                    queue_text(cfg_pattern[8*k +: 8], close && made == count - 1);
                    made++;
                end
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < noise_pct)
                    ch = 8'($urandom_range(0, 255));
                else if (pick < noise_pct + 10)
                    ch = NEWLINE_CODE;
                else
                    ch = cfg_pattern[8*$urandom_range(0, 7) +: 8];
                queue_text(ch, close && made == count - 1);
                made++;
            end
        end
    endtask

    // Hold until every queued request is taken and every result has come back
    task automatic wait_idle();
        do @(negedge clk);
        while (bytes_taken != bytes_queued || predicted_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Drive text requests at the falling edge, holding a stalled one
    always @(negedge clk)
    begin : text_driver
        if (!rst_n)
            text_valid <= 1'b0;
        else if (!text_valid || text_taken)
        begin
            if (text_gap > 0)
            begin
                text_valid <= 1'b0;
                text_gap   <= text_gap - 1;
            end
            else if (pending_text.size() != 0)
            begin
                text_data  <= pending_text.pop_front();
                text_valid <= 1'b1;
                text_gap   <= draw_wait(send_idle_pct);
            end
            else
                text_valid <= 1'b0;
        end
    end

    // After each taken result, stall the result channel for a wait drawn by draw_wait
    always @(negedge clk)
    begin : result_stall_driver
        int n;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else if (result_taken)
        begin
            n = draw_wait(recv_idle_pct);
            result_stall <= (n != 0);
            stall_left   <= (n > 0) ? n - 1 : 0;
        end
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else
            result_stall <= 1'b0;
    end

    // Predict on each accepted text request, check each accepted result request
    always @(posedge clk)
    begin : monitor
        result_t want;
        text_taken   <= rst_n && text_valid && !text_stall;
        result_taken <= rst_n && result_valid && !result_stall;
        if (rst_n && text_valid && !text_stall)
        begin
            predicted_results.push_back(locate_match(text_data));
            bytes_taken++;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_results.size() == 0)
            begin
                failures++;
                $display("%0t ns: result expected none actual %h", $time, result_data);
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("match_found", OUT_W'(want.match_found),
                            OUT_W'(result_data.match_found));
                check_field("match_start", want.match_start, result_data.match_start);
                check_field("match_line", want.match_line, result_data.match_line);
                check_field("match_column", want.match_column, result_data.match_column);
                check_field("match_total", want.match_total, result_data.match_total);
                check_field("end_of_text", OUT_W'(want.end_of_text),
                            OUT_W'(result_data.end_of_text));
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (text_valid && !text_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("text_pattern_match_locator_unit_test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int               random_items;
        int               buffers;
        int               count;
        int               noise_pct;
        bit               close;
        logic [63:0]      pat;
        logic [LEN_W-1:0] len;
        cfg_pattern = '0;
        cfg_length  = LEN_W'(1);
        clear_stream();
        random_items = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset pattern is one zero byte; the final byte never matches
        queue_text(8'h00, 1'b0);
        queue_text(8'hFF, 1'b0);
        queue_text(8'h00, 1'b1);
        wait_idle();

        // overlapping matches across a newline, last match ends on the final byte
        set_reg(REG_PATTERN_BYTES, {40'b0, CHAR_A, CHAR_B, CHAR_A});
        set_reg(REG_PATTERN_LENGTH, 64'd3);
        queue_string("aba\nababa", 1'b1);
        wait_idle();

        // single byte pattern with the same byte marked final
        set_reg(REG_PATTERN_BYTES, 64'h78);
        set_reg(REG_PATTERN_LENGTH, 64'd1);
        queue_string("xx", 1'b1);
        wait_idle();

        // zero length never matches
        set_reg(REG_PATTERN_BYTES, 64'h0);
        set_reg(REG_PATTERN_LENGTH, 64'd0);
        queue_text(8'h00, 1'b0);
        queue_text(8'h00, 1'b0);
        wait_idle();

        // oversized length is capped to the full window
        set_reg(REG_PATTERN_BYTES, {64{1'b1}});
        set_reg(REG_PATTERN_LENGTH, 64'd15);
        for (int i = 0; i < MAX_PAT; i++)
            queue_text(8'hFF, i == MAX_PAT - 1);
        wait_idle();

        // random phases, each with its own pattern, length and idle mix
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
                pat = {$urandom, $urandom};
            else
                for (int k = 0; k < 8; k++)
                    pat[8*k +: 8] = ($urandom_range(0, 7) == 0) ? NEWLINE_CODE :
                                    ($urandom_range(0, 1) ? CHAR_A : CHAR_B);
            len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 15))
                                              : LEN_W'($urandom_range(1, 8));
            set_reg(REG_PATTERN_BYTES, pat);
            set_reg(REG_PATTERN_LENGTH, {60'b0, len});
            case ($urandom_range(0, 2))
                0: send_idle_pct = 0;
                1: send_idle_pct = 25;
                default: send_idle_pct = 100;
            endcase
            case ($urandom_range(0, 2))
                0: recv_idle_pct = 0;
                1: recv_idle_pct = 25;
                default: recv_idle_pct = 100;
            endcase
            noise_pct = ($urandom_range(0, 3) == 0) ? 60 : int'($urandom_range(0, 15));
            buffers = $urandom_range(1, 3);
            for (int b = 0; b < buffers; b++)
            begin
                count = $urandom_range(1, 40);
                close = (b < buffers - 1) || ($urandom_range(0, 3) != 0);
                queue_buffer(count, close, noise_pct);
                random_items += count;
            end
            wait_idle();
        end

        if (failures == 0)
            $display("text_pattern_match_locator_unit_test passed");
        else
            $display("text_pattern_match_locator_unit_test failed");
        $finish;
    end

endmodule
